// ===== rtl/scroll_delta_quantizer_defines.svh =====
// assertion macros shared by the scroll delta quantizer
`ifndef SCROLL_DELTA_QUANTIZER_DEFINES_SVH
`define SCROLL_DELTA_QUANTIZER_DEFINES_SVH

// same-cycle implication, gated off during reset
`define SDQ_ASSERT_SAME(LABEL, CLK, RSTN, ANTE, CONS) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("scroll delta quantizer check failed");

// next-cycle implication, gated off during reset
`define SDQ_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error("scroll delta quantizer check failed");

`endif

// ===== rtl/sdq_pkg.sv =====
package sdq_pkg;

    // field widths
    localparam int DELTA_W = 32;
    localparam int TIME_W  = 32;
    localparam int STEP_W  = 16;
    localparam int GAP_W   = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // defaults
    localparam int FRACTION_BITS_DEFAULT = 16;
    localparam logic [GAP_W-1:0] IDLE_GAP_RESET = GAP_W'(1000);
    localparam logic INVERT_RESET = 1'b1;
    localparam logic BYPASS_RESET = 1'b0;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IDLE_GAP = 8'd0,
        REG_INVERT   = 8'd1,
        REG_BYPASS   = 8'd2
    } cfg_reg_t;

    // live configuration
    typedef struct packed {
        logic [GAP_W-1:0] idle_gap;
        logic             invert;
        logic             bypass;
    } cfg_t;

    // per-axis control from the top level
    typedef struct packed {
        logic en;
        logic clear;
        logic bypass;
        logic invert;
    } axis_ctrl_t;

endpackage

// ===== rtl/sdq_if.sv =====
// scroll event request channel
interface sdq_event_if;
    logic                                valid;
    logic                                ready;
    logic signed [sdq_pkg::DELTA_W-1:0]  delta_x;
    logic signed [sdq_pkg::DELTA_W-1:0]  delta_y;
    logic        [sdq_pkg::TIME_W-1:0]   time_ms;

    modport source (output valid, output delta_x, output delta_y, output time_ms, input ready);
    modport sink   (input valid, input delta_x, input delta_y, input time_ms, output ready);
endinterface

// whole-step result channel
interface sdq_step_if;
    logic                               valid;
    logic                               ready;
    logic signed [sdq_pkg::STEP_W-1:0]  step_x;
    logic signed [sdq_pkg::STEP_W-1:0]  step_y;

    modport source (output valid, output step_x, output step_y, input ready);
    modport sink   (input valid, input step_x, input step_y, output ready);
endinterface

// configuration write channel
interface sdq_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sdq_pkg::CFG_IDX_W-1:0]      index;
    logic [sdq_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sdq_cfg.sv =====
module sdq_cfg (
    input  logic             clk,
    input  logic             rst_n,
    sdq_cfg_if.sink          cfg_wr,
    output sdq_pkg::cfg_t    cfg
);

    sdq_pkg::cfg_t cfg_reg;

    // writes are always taken
    assign cfg_wr.ready = 1'b1;
    assign cfg = cfg_reg;

    // register file, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_gap <= sdq_pkg::IDLE_GAP_RESET;
            cfg_reg.invert   <= sdq_pkg::INVERT_RESET;
            cfg_reg.bypass   <= sdq_pkg::BYPASS_RESET;
        end
        else if (cfg_wr.valid)
        begin
            unique case (cfg_wr.index)
                sdq_pkg::REG_IDLE_GAP: cfg_reg.idle_gap <= cfg_wr.data[sdq_pkg::GAP_W-1:0];
                sdq_pkg::REG_INVERT:   cfg_reg.invert   <= cfg_wr.data[0];
                sdq_pkg::REG_BYPASS:   cfg_reg.bypass   <= cfg_wr.data[0];
                default:               cfg_reg          <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== rtl/sdq_axis.sv =====
module sdq_axis #(
    parameter int FRACTION_BITS = sdq_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sdq_pkg::axis_ctrl_t                ctrl,
    input  logic signed [sdq_pkg::DELTA_W-1:0] delta,
    output logic signed [sdq_pkg::STEP_W-1:0]  step
);

    localparam int DW = FRACTION_BITS + 2;
    localparam int MW = sdq_pkg::DELTA_W + 1;
    localparam int SW = sdq_pkg::DELTA_W + 2;
    localparam int SPW = sdq_pkg::STEP_W;
    localparam logic [SW-1:0] ROUND_ADD = SW'((64'd1 << FRACTION_BITS) - 64'd1);
    localparam logic [DW:0]   ONE_KEEP  = (DW+1)'(64'd1 << FRACTION_BITS);
    localparam logic [SW-1:0] STEP_POS_LIM = SW'((64'd1 << (SPW - 1)) - 64'd1);
    localparam logic [SW-1:0] STEP_NEG_LIM = SW'(64'd1 << (SPW - 1));
    localparam logic [DW:0]   DEF_POS_LIM  = (DW+1)'((64'd1 << (DW - 1)) - 64'd1);
    localparam logic [DW:0]   DEF_NEG_LIM  = (DW+1)'(64'd1 << (DW - 1));

    logic signed [DW-1:0]     deficit_reg;
    logic signed [DW-1:0]     deficit_next;
    logic signed [DW-1:0]     f_base;
    logic signed [DW-1:0]     f_eff;
    logic [DW-1:0]            f_abs;
    logic signed [MW-1:0]     d;
    logic                     d_neg;
    logic                     d_zero;
    logic                     f_neg;
    logic [MW-1:0]            d_mag;
    logic [MW-1:0]            f_mag;
    logic [MW-1:0]            t_mag;
    logic [MW-1:0]            t_neg;
    logic [SW-1:0]            round_sum;
    logic [SW-1:0]            step_mag;
    logic [FRACTION_BITS-1:0] rem;
    logic [DW:0]              keep_mag;
    logic                     bigger;

    // sign and clamp of a magnitude into the step range
    function automatic logic signed [SPW-1:0] sat_step(input logic neg, input logic [SW-1:0] m);
        logic [SW-1:0] lim;
        logic [SW-1:0] mm;
        logic [SW-1:0] s;
        lim = neg ? STEP_NEG_LIM : STEP_POS_LIM;
        mm  = (m > lim) ? lim : m;
        s   = neg ? (~mm + SW'(1)) : mm;
        return s[SPW-1:0];
    endfunction

    // sign and clamp of a magnitude into the deficit range
    function automatic logic signed [DW-1:0] sat_def(input logic neg, input logic [DW:0] m);
        logic [DW:0] lim;
        logic [DW:0] mm;
        logic [DW:0] s;
        lim = neg ? DEF_NEG_LIM : DEF_POS_LIM;
        mm  = (m > lim) ? lim : m;
        s   = neg ? (~mm + (DW+1)'(1)) : mm;
        return s[DW-1:0];
    endfunction

    // delta after optional inversion, at full width
    always_comb
    begin
        d      = ctrl.invert ? -MW'(delta) : MW'(delta);
        d_neg  = d[MW-1];
        d_zero = (d == '0);
        d_mag  = d_neg ? (~d + MW'(1)) : d;
    end

    // deficit after idle clear and direction change
    always_comb
    begin
        f_base = ctrl.clear ? '0 : deficit_reg;
        f_eff  = f_base;
        if (f_base != '0 && f_base[DW-1] != d_neg)
        begin
            f_eff = '0;
        end
        f_neg = f_eff[DW-1];
        f_abs = f_neg ? (~f_eff + DW'(1)) : f_eff;
        f_mag = MW'(f_abs);
    end

    // rounding away from zero (truncation in bypass) and the two deficit updates
    always_comb
    begin
        bigger    = d_mag > f_mag;
        t_mag     = d_mag - f_mag;
        t_neg     = ~t_mag + MW'(1);
        rem       = t_neg[FRACTION_BITS-1:0];
        round_sum = SW'(t_mag) + ROUND_ADD;
        keep_mag  = (DW+1)'(f_abs) - (DW+1)'(d_mag[DW-1:0]) + ONE_KEEP;

        if (ctrl.bypass)
        begin
            step_mag = SW'(d_mag >> FRACTION_BITS);
        end
        else if (bigger)
        begin
            step_mag = round_sum >> FRACTION_BITS;
        end
        else
        begin
            step_mag = SW'(1);
        end

        if (ctrl.bypass || d_zero)
        begin
            deficit_next = f_base;
        end
        else if (bigger)
        begin
            deficit_next = d_neg ? -DW'(rem) : DW'(rem);
        end
        else
        begin
            deficit_next = sat_def(d_neg, keep_mag);
        end

        step = d_zero ? '0 : sat_step(d_neg, step_mag);
    end

    // deficit register, held in bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deficit_reg <= '0;
        end
        else if (ctrl.en && !ctrl.bypass)
        begin
            deficit_reg <= deficit_next;
        end
    end

endmodule

// ===== rtl/scroll_delta_quantizer.sv =====
// Scroll delta quantizer: turns fractional Q(32-FRACTION_BITS).FRACTION_BITS scroll deltas
// into whole saturated steps, carrying a per-axis deficit so outside bypass a nonzero delta always
// scrolls at least one step and the overshoot is eaten by later deltas in the same
// direction. One event is taken every cycle unless stalled; a request is held in the input
// register, is quantized by single-pass logic that also updates the deficits, and
// lands in the output register once that register is empty or being drained.
// The only stall is a full output register with ready low. Configuration writes are
// taken at once and should only be issued while no event is in flight.
`include "scroll_delta_quantizer_defines.svh"

module scroll_delta_quantizer #(
    parameter int FRACTION_BITS = sdq_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    sdq_event_if.sink      scroll,
    sdq_step_if.source     steps,
    sdq_cfg_if.sink        cfg_wr
);

    sdq_pkg::cfg_t                      cfg;
    sdq_pkg::axis_ctrl_t                axis_ctrl;
    logic                               stage_valid_reg;
    logic signed [sdq_pkg::DELTA_W-1:0] dx_reg;
    logic signed [sdq_pkg::DELTA_W-1:0] dy_reg;
    logic        [sdq_pkg::TIME_W-1:0]  time_reg;
    logic        [sdq_pkg::TIME_W-1:0]  last_event_time_reg;
    logic        [sdq_pkg::TIME_W-1:0]  gap;
    logic                               timeout;
    logic                               out_valid_reg;
    logic signed [sdq_pkg::STEP_W-1:0]  step_x_reg;
    logic signed [sdq_pkg::STEP_W-1:0]  step_y_reg;
    logic signed [sdq_pkg::STEP_W-1:0]  step_x_w;
    logic signed [sdq_pkg::STEP_W-1:0]  step_y_w;
    logic                               fire;
    logic                               take;

    // configuration registers
    sdq_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .cfg    (cfg)
    );

    // handshake
    assign fire         = stage_valid_reg && (!out_valid_reg || steps.ready);
    assign scroll.ready = !stage_valid_reg || fire;
    assign take         = scroll.valid && scroll.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dx_reg   <= scroll.delta_x;
            dy_reg   <= scroll.delta_y;
            time_reg <= scroll.time_ms;
        end
    end

    // idle gap check against the last handled event
    assign gap     = time_reg - last_event_time_reg;
    assign timeout = gap > sdq_pkg::TIME_W'(cfg.idle_gap);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_event_time_reg <= '0;
        end
        else if (fire && !cfg.bypass)
        begin
            last_event_time_reg <= time_reg;
        end
    end

    // per-axis quantizers
    assign axis_ctrl.en     = fire;
    assign axis_ctrl.clear  = timeout && !cfg.bypass;
    assign axis_ctrl.bypass = cfg.bypass;
    assign axis_ctrl.invert = cfg.invert;

    sdq_axis #(.FRACTION_BITS(FRACTION_BITS)) u_axis_x (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (axis_ctrl),
        .delta (dx_reg),
        .step  (step_x_w)
    );

    sdq_axis #(.FRACTION_BITS(FRACTION_BITS)) u_axis_y (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (axis_ctrl),
        .delta (dy_reg),
        .step  (step_y_w)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (steps.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            step_x_reg <= step_x_w;
            step_y_reg <= step_y_w;
        end
    end

    assign steps.valid  = out_valid_reg;
    assign steps.step_x = step_x_reg;
    assign steps.step_y = step_y_reg;

    // checks
    `SDQ_ASSERT_NEXT(a_stage_held, clk, rst_n,
                     stage_valid_reg && out_valid_reg && !steps.ready, stage_valid_reg)
    `SDQ_ASSERT_NEXT(a_fire_fills_out, clk, rst_n, fire, out_valid_reg)
    `SDQ_ASSERT_NEXT(a_bypass_keeps_time, clk, rst_n, fire && cfg.bypass,
                     $stable(last_event_time_reg))
    `SDQ_ASSERT_SAME(a_full_blocks_input, clk, rst_n,
                     stage_valid_reg && out_valid_reg && !steps.ready, !scroll.ready)

endmodule
